@@ sv/dcm_pkg.sv @@
// shared types and constants for the diverging colour map
package dcm_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_COUNT   = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NEG_LOW  = 2'd0,
        CFG_NEG_HIGH = 2'd1,
        CFG_POS_LOW  = 2'd2,
        CFG_POS_HIGH = 2'd3
    } t_cfg_reg;

    // stop colours in halves: 0 is 0.0, 1 is 0.5, 2 is 1.0
    typedef logic [1:0] t_half;
    typedef logic [2:0] t_stop_idx;

    localparam int STOP_COUNT = 6;
    localparam int CHANNELS   = 3;

    localparam t_stop_idx STOP_BLUE   = 3'd0;
    localparam t_stop_idx STOP_CYAN   = 3'd1;
    localparam t_stop_idx STOP_GREEN  = 3'd2;
    localparam t_stop_idx STOP_PURPLE = 3'd3;
    localparam t_stop_idx STOP_ORANGE = 3'd4;
    localparam t_stop_idx STOP_RED    = 3'd5;

    // order of channels: red, green, blue
    localparam t_half STOP_RGB [STOP_COUNT][CHANNELS] = '{
        '{2'd0, 2'd0, 2'd2},
        '{2'd0, 2'd2, 2'd2},
        '{2'd0, 2'd2, 2'd0},
        '{2'd2, 2'd0, 2'd2},
        '{2'd2, 2'd1, 2'd0},
        '{2'd2, 2'd0, 2'd0}
    };

    // control that travels alongside each word down the pipe
    typedef struct packed {
        logic valid;
        logic neg;
        logic div;
        logic flag;
    } t_ctl;

endpackage

@@ sv/dcm_front.sv @@
// range selection, magnitudes and special cases ahead of the divider cells
module dcm_front #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [SAMPLE_WIDTH-1:0]  i_sample,
    input  logic [SAMPLE_WIDTH-1:0]  i_neg_low,
    input  logic [SAMPLE_WIDTH-1:0]  i_neg_high,
    input  logic [SAMPLE_WIDTH-1:0]  i_pos_low,
    input  logic [SAMPLE_WIDTH-1:0]  i_pos_high,
    output dcm_pkg::t_ctl            o_ctl,
    output logic [SAMPLE_WIDTH-1:0]  o_rem,
    output logic [SAMPLE_WIDTH-1:0]  o_den,
    output logic [FRACTION_BITS:0]   o_quo
);
    import dcm_pkg::*;

    localparam int W = SAMPLE_WIDTH;
    localparam int F = FRACTION_BITS;
    localparam logic [F:0] Q_ONE = (F+1)'(1) << F;

    // stage a: signed differences
    t_ctl         r_a_ctl;
    logic [W:0]   r_a_num;
    logic [W:0]   r_a_den;
    t_ctl         n_a_ctl;
    logic [W:0]   n_a_num;
    logic [W:0]   n_a_den;
    logic [W-1:0] lo;
    logic [W-1:0] hi;

    // stage b: magnitudes and signs
    t_ctl         r_b_ctl;
    logic [W-1:0] r_b_n;
    logic [W-1:0] r_b_d;
    logic         r_b_nneg;
    logic         r_b_dneg;
    logic [W:0]   num_neg;
    logic [W:0]   den_neg;

    // stage c: special cases
    t_ctl         r_c_ctl;
    logic [W-1:0] r_c_rem;
    logic [W-1:0] r_c_den;
    logic [F:0]   r_c_quo;
    t_ctl         n_c_ctl;
    logic [F:0]   n_c_quo;

    always_comb begin
        n_a_ctl       = '0;
        n_a_ctl.valid = i_valid;
        n_a_ctl.neg   = i_sample[W-1];
        lo            = i_sample[W-1] ? i_neg_low  : i_pos_low;
        hi            = i_sample[W-1] ? i_neg_high : i_pos_high;
        n_a_num       = {i_sample[W-1], i_sample} - {lo[W-1], lo};
        n_a_den       = {hi[W-1], hi} - {lo[W-1], lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= n_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_num <= n_a_num;
            r_a_den <= n_a_den;
        end
    end

    assign num_neg = ~r_a_num + (W+1)'(1);
    assign den_neg = ~r_a_den + (W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_nneg <= r_a_num[W];
            r_b_dneg <= r_a_den[W];
            r_b_n    <= r_a_num[W] ? num_neg[W-1:0] : r_a_num[W-1:0];
            r_b_d    <= r_a_den[W] ? den_neg[W-1:0] : r_a_den[W-1:0];
        end
    end

    always_comb begin
        n_c_ctl       = r_b_ctl;
        n_c_ctl.div   = 1'b0;
        n_c_ctl.flag  = 1'b0;
        n_c_quo       = '0;
        if (r_b_d == '0) begin
            // zero span gives green and raises the flag
            n_c_ctl.flag = 1'b1;
        end else if (r_b_n == '0) begin
            n_c_quo = '0;
        end else if (r_b_nneg != r_b_dneg) begin
            n_c_ctl.flag = 1'b1;
        end else if (r_b_n >= r_b_d) begin
            n_c_quo      = Q_ONE;
            n_c_ctl.flag = (r_b_n != r_b_d);
        end else begin
            n_c_ctl.div = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else if (i_en) begin
            r_c_ctl <= n_c_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_rem <= r_b_n;
            r_c_den <= r_b_d;
            r_c_quo <= n_c_quo;
        end
    end

    assign o_ctl = r_c_ctl;
    assign o_rem = r_c_rem;
    assign o_den = r_c_den;
    assign o_quo = r_c_quo;

endmodule

@@ sv/dcm_div_cell.sv @@
// one restoring division cell: one quotient bit per cell
module dcm_div_cell #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  dcm_pkg::t_ctl            i_ctl,
    input  logic [SAMPLE_WIDTH-1:0]  i_rem,
    input  logic [SAMPLE_WIDTH-1:0]  i_den,
    input  logic [FRACTION_BITS:0]   i_quo,
    output dcm_pkg::t_ctl            o_ctl,
    output logic [SAMPLE_WIDTH-1:0]  o_rem,
    output logic [SAMPLE_WIDTH-1:0]  o_den,
    output logic [FRACTION_BITS:0]   o_quo
);
    import dcm_pkg::*;

    localparam int W = SAMPLE_WIDTH;
    localparam int F = FRACTION_BITS;

    t_ctl         r_ctl;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_den;
    logic [F:0]   r_quo;
    logic [W-1:0] n_rem;
    logic [F:0]   n_quo;
    logic [W:0]   rem2;
    logic [W+1:0] diff;
    logic         ge;

    always_comb begin
        rem2  = {i_rem, 1'b0};
        diff  = {1'b0, rem2} - {2'b00, i_den};
        ge    = ~diff[W+1];
        n_rem = i_rem;
        n_quo = i_quo;
        if (i_ctl.div) begin
            // remainder stays below the divisor, so W bits hold it
            n_rem = ge ? diff[W-1:0] : rem2[W-1:0];
            n_quo = {i_quo[F-1:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

@@ sv/dcm_colour.sv @@
// segment choice and per-channel interpolation scaled by 255
module dcm_colour #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  dcm_pkg::t_ctl           i_ctl,
    input  logic [FRACTION_BITS:0]  i_quo,
    output logic                    o_valid,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue,
    output logic                    o_clamped
);
    import dcm_pkg::*;

    localparam int F = FRACTION_BITS;
    localparam logic [F:0] Q_ONE  = (F+1)'(1) << F;
    localparam logic [F:0] Q_HALF = (F+1)'(1) << (F-1);

    // stage d: segment and offset within it
    t_ctl       r_d_ctl;
    t_stop_idx  r_d_seg;
    logic [F:0] r_d_off;
    t_stop_idx  n_d_seg;
    logic [F:0] n_d_off;

    // stage e: output word
    logic       r_valid;
    logic [7:0] r_chan [CHANNELS];
    logic       r_clamped;
    logic [7:0] n_chan [CHANNELS];

    always_comb begin
        n_d_seg = STOP_CYAN;
        n_d_off = Q_HALF;
        if (i_ctl.neg) begin
            if (i_quo >= Q_HALF) begin
                n_d_seg = STOP_BLUE;
                n_d_off = Q_ONE - i_quo;
            end else begin
                n_d_seg = STOP_CYAN;
                n_d_off = Q_HALF - i_quo;
            end
        end else if (i_quo == '0) begin
            n_d_seg = STOP_CYAN;
            n_d_off = Q_HALF;
        end else if (i_quo <= Q_HALF) begin
            n_d_seg = STOP_PURPLE;
            n_d_off = i_quo;
        end else begin
            n_d_seg = STOP_ORANGE;
            n_d_off = i_quo - Q_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else if (i_en) begin
            r_d_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_seg <= n_d_seg;
            r_d_off <= n_d_off;
        end
    end

    // level = c0*half + off*(c1-c0), lies in 0..one; then times 255
    always_comb begin
        logic        [1:0]  c0;
        logic        [1:0]  c1;
        logic signed [2:0]  dc;
        logic signed [F+2:0] base;
        logic signed [F+2:0] offx;
        logic signed [F+2:0] term;
        logic        [F+2:0] lvl;
        logic        [F+10:0] scaled;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            c0     = STOP_RGB[r_d_seg][ch];
            c1     = STOP_RGB[r_d_seg + t_stop_idx'(1)][ch];
            dc     = signed'({1'b0, c1}) - signed'({1'b0, c0});
            base   = signed'((F+3)'(c0) << (F-1));
            offx   = signed'({2'b00, r_d_off});
            case (dc)
                -3'sd2:  term = -(offx <<< 1);
                -3'sd1:  term = -offx;
                3'sd1:   term = offx;
                3'sd2:   term = offx <<< 1;
                default: term = '0;
            endcase
            lvl    = unsigned'(base + term);
            scaled = ({8'd0, lvl} << 8) - {8'd0, lvl};
            n_chan[ch] = scaled[F+7:F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_d_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chan    <= n_chan;
            r_clamped <= r_d_ctl.flag;
        end
    end

    assign o_valid   = r_valid;
    assign o_red     = r_chan[0];
    assign o_green   = r_chan[1];
    assign o_blue    = r_chan[2];
    assign o_clamped = r_clamped;

endmodule

@@ sv/diverging_colormap_rgb_core.sv @@
// a sample goes through front stages a-c, the divider cells and colour stages d-e
// throughput: one word per cycle; the whole pipe, input included, holds while a result waits
// the divider is a chain of FRACTION_BITS cells, one quotient bit per cell
// reset clears all valid flags and loads the range registers with their default bounds
// input ready follows the output handshake in the same cycle
// top level of the diverging colour map
module diverging_colormap_rgb_core #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [SAMPLE_WIDTH-1:0]           i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_red,
    output logic [7:0]                        o_green,
    output logic [7:0]                        o_blue,
    output logic                              o_clamped,
    input  logic                              i_cfg_we,
    input  logic [dcm_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]           i_cfg_data
);
    import dcm_pkg::*;

    localparam int W = SAMPLE_WIDTH;
    localparam int F = FRACTION_BITS;

    localparam logic [W-1:0] NEG_LOW_RST  = W'(-32768);
    localparam logic [W-1:0] NEG_HIGH_RST = W'(-1);
    localparam logic [W-1:0] POS_LOW_RST  = W'(0);
    localparam logic [W-1:0] POS_HIGH_RST = W'(32767);

    logic [W-1:0] r_neg_low;
    logic [W-1:0] r_neg_high;
    logic [W-1:0] r_pos_low;
    logic [W-1:0] r_pos_high;
    logic         en;

    t_ctl         cell_ctl [F+1];
    logic [W-1:0] cell_rem [F+1];
    logic [W-1:0] cell_den [F+1];
    logic [F:0]   cell_quo [F+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_low  <= NEG_LOW_RST;
            r_neg_high <= NEG_HIGH_RST;
            r_pos_low  <= POS_LOW_RST;
            r_pos_high <= POS_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_NEG_LOW:  r_neg_low  <= i_cfg_data;
                CFG_NEG_HIGH: r_neg_high <= i_cfg_data;
                CFG_POS_LOW:  r_pos_low  <= i_cfg_data;
                CFG_POS_HIGH: r_pos_high <= i_cfg_data;
            endcase
        end
    end

    // pipe moves whenever the output register is empty or being taken
    assign en         = ~o_out_valid | i_out_ready;
    assign o_in_ready = en;

    dcm_front #(
        .SAMPLE_WIDTH  (W),
        .FRACTION_BITS (F)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_sample   (i_sample),
        .i_neg_low  (r_neg_low),
        .i_neg_high (r_neg_high),
        .i_pos_low  (r_pos_low),
        .i_pos_high (r_pos_high),
        .o_ctl      (cell_ctl[0]),
        .o_rem      (cell_rem[0]),
        .o_den      (cell_den[0]),
        .o_quo      (cell_quo[0])
    );

    for (genvar g = 0; g < F; g++) begin : g_cell
        dcm_div_cell #(
            .SAMPLE_WIDTH  (W),
            .FRACTION_BITS (F)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (cell_ctl[g]),
            .i_rem   (cell_rem[g]),
            .i_den   (cell_den[g]),
            .i_quo   (cell_quo[g]),
            .o_ctl   (cell_ctl[g+1]),
            .o_rem   (cell_rem[g+1]),
            .o_den   (cell_den[g+1]),
            .o_quo   (cell_quo[g+1])
        );
    end

    dcm_colour #(
        .FRACTION_BITS (F)
    ) u_colour (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_ctl     (cell_ctl[F]),
        .i_quo     (cell_quo[F]),
        .o_valid   (o_out_valid),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue),
        .o_clamped (o_clamped)
    );

endmodule
